FILE: rtl/core/rv64im_decode_execute_macros.svh
// assertion macros for the rv64im decode/execute block
// expects clk and rst_n in the scope where a macro is used
`ifndef RV64IM_DECODE_EXECUTE_MACROS_SVH
`define RV64IM_DECODE_EXECUTE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RVDE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define RVDE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/rvde_pkg.sv
// shared types, codes and constants of the rv64im decode/execute block
// no dependencies
`timescale 1ns / 1ps

package rvde_pkg;

    localparam int XLEN         = 64;
    localparam int DIV_STEPS    = XLEN;
    localparam int MD_STAGES    = DIV_STEPS + 2;

    // major opcodes
    localparam logic [6:0] OPC_LOAD    = 7'h03;
    localparam logic [6:0] OPC_OPIMM   = 7'h13;
    localparam logic [6:0] OPC_AUIPC   = 7'h17;
    localparam logic [6:0] OPC_OPIMM32 = 7'h1b;
    localparam logic [6:0] OPC_STORE   = 7'h23;
    localparam logic [6:0] OPC_OP      = 7'h33;
    localparam logic [6:0] OPC_LUI     = 7'h37;
    localparam logic [6:0] OPC_OP32    = 7'h3b;
    localparam logic [6:0] OPC_BRANCH  = 7'h63;
    localparam logic [6:0] OPC_JALR    = 7'h67;
    localparam logic [6:0] OPC_JAL     = 7'h6f;
    localparam logic [6:0] OPC_SYSTEM  = 7'h73;

    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [5:0] F6_BASE   = 6'h00;
    localparam logic [5:0] F6_ALT    = 6'h10;

    // integer funct3
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // branch funct3
    localparam logic [2:0] BR_EQ  = 3'd0;
    localparam logic [2:0] BR_NE  = 3'd1;
    localparam logic [2:0] BR_LT  = 3'd4;
    localparam logic [2:0] BR_GE  = 3'd5;
    localparam logic [2:0] BR_LTU = 3'd6;
    localparam logic [2:0] BR_GEU = 3'd7;

    localparam logic [2:0] LOAD_F3_INVALID = 3'd7;
    localparam logic [2:0] LOAD_F3_UNSIGNED = 3'd3;
    localparam logic [2:0] STORE_F3_MAX    = 3'd3;
    localparam logic [2:0] SYS_F3_PRIV     = 3'd0;

    localparam logic [1:0] CSR_RW = 2'd1;
    localparam logic [1:0] CSR_RS = 2'd2;
    localparam logic [1:0] CSR_RC = 2'd3;

    localparam logic [31:0] INSN_ECALL  = 32'h0000_0073;
    localparam logic [31:0] INSN_MRET   = 32'h3020_0073;
    localparam logic [31:0] INSN_EBREAK = 32'h0010_0073;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_ECALL   = 3'd1;
    localparam logic [2:0] EV_MRET    = 3'd2;
    localparam logic [2:0] EV_EBREAK  = 3'd3;
    localparam logic [2:0] EV_ILLEGAL = 3'd4;

    typedef enum logic [3:0] {
        ALU_ADD, ALU_SUB, ALU_SLL, ALU_SLT, ALU_SLTU,
        ALU_XOR, ALU_SRL, ALU_SRA, ALU_OR, ALU_AND
    } alu_op_t;

    typedef enum logic [2:0] {
        RES_ZERO, RES_ALU, RES_IMM, RES_PC_IMM, RES_PC4, RES_CSR, RES_MD
    } res_sel_t;

    typedef enum logic [1:0] {
        FLOW_SEQ, FLOW_BRANCH, FLOW_JAL, FLOW_JALR
    } flow_t;

    // order follows funct3 of the M extension
    typedef enum logic [2:0] {
        MD_MUL, MD_MULH, MD_MULHSU, MD_MULHU, MD_DIV, MD_DIVU, MD_REM, MD_REMU
    } md_op_t;

    typedef struct packed {
        logic [31:0] instruction;
        logic [63:0] pc;
        logic [63:0] rs1_value;
        logic [63:0] rs2_value;
        logic [63:0] csr_read_value;
    } instr_t;

    typedef struct packed {
        logic        rd_write;
        logic [4:0]  rd_index;
        logic [63:0] rd_value;
        logic [63:0] next_pc;
        logic [1:0]  mem_kind;
        logic [63:0] mem_address;
        logic [1:0]  mem_size_log2;
        logic        load_signed;
        logic [63:0] store_data;
        logic        csr_write;
        logic [63:0] csr_new_value;
        logic [2:0]  event_res;
    } result_t;

    typedef struct packed {
        logic        rd_write;
        logic [4:0]  rd_index;
        res_sel_t    res_sel;
        alu_op_t     alu_op;
        logic        word;
        logic        use_imm;
        logic [63:0] imm;
        flow_t       flow;
        logic [2:0]  br_f3;
        logic [1:0]  mem_kind;
        logic [1:0]  mem_size;
        logic        load_signed;
        logic        csr_write;
        logic [1:0]  csr_op;
        logic [2:0]  event_res;
        md_op_t      md_op;
        logic [63:0] pc;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] csr;
    } dec_t;

    typedef struct packed {
        result_t     res;
        logic        is_md;
        md_op_t      md_op;
        logic        md_word;
        logic        neg;
        logic        bz;
        logic [63:0] corr;
    } carry_t;

    typedef struct packed {
        carry_t      c;
        logic [63:0] op_a;
        logic [63:0] op_b;
    } ex_t;

    // r/q: remainder and quotient, or high and low product; d/e: divisor or cross products
    typedef struct packed {
        logic [63:0] r;
        logic [63:0] q;
        logic [63:0] d;
        logic [63:0] e;
    } md_state_t;

    function automatic logic [63:0] sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

FILE: rtl/core/rvde_instr_if.sv
// instruction channel: valid/ready handshake carrying one instruction transaction
// depends on rvde_pkg
`timescale 1ns / 1ps

interface rvde_instr_if;
    import rvde_pkg::*;
    logic   valid;
    logic   ready;
    instr_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/rvde_result_if.sv
// result channel: valid/ready handshake carrying one result transaction
// depends on rvde_pkg
`timescale 1ns / 1ps

interface rvde_result_if;
    import rvde_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/rvde_decode.sv
// decode stage: instruction fields, immediates and control, one register stage
// depends on rvde_pkg and rvde_instr_if
`timescale 1ns / 1ps

module rvde_decode
    import rvde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rvde_instr_if.sink  instr,
    output logic        out_valid,
    input  logic        out_ready,
    output dec_t        out_data
);

    logic v_reg;
    dec_t d_reg;
    dec_t d_next;
    logic adv;

    assign adv         = !v_reg || out_ready;
    assign instr.ready = adv;
    assign out_valid   = v_reg;
    assign out_data    = d_reg;

    always_comb
    begin
        logic [31:0] ins;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [63:0] imm_i;
        logic [63:0] imm_s;
        logic [63:0] imm_b;
        logic [63:0] imm_j;
        logic [63:0] imm_u;
        logic        ill;
        logic        wr;

        ins   = instr.data.instruction;
        opc   = ins[6:0];
        f3    = ins[14:12];
        f7    = ins[31:25];
        imm_i = {{52{ins[31]}}, ins[31:20]};
        imm_s = {{52{ins[31]}}, ins[31:25], ins[11:7]};
        imm_b = {{51{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        imm_j = {{43{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        imm_u = {{32{ins[31]}}, ins[31:12], 12'b0};
        ill   = 1'b0;
        wr    = 1'b0;

        d_next             = '0;
        d_next.rd_index    = ins[11:7];
        d_next.res_sel     = RES_ZERO;
        d_next.alu_op      = ALU_ADD;
        d_next.use_imm     = 1'b1;
        d_next.imm         = imm_i;
        d_next.flow        = FLOW_SEQ;
        d_next.br_f3       = f3;
        d_next.mem_kind    = MEM_NONE;
        d_next.csr_op      = f3[1:0];
        d_next.event_res   = EV_NONE;
        d_next.md_op       = md_op_t'(f3);
        d_next.pc          = instr.data.pc;
        d_next.a           = instr.data.rs1_value;
        d_next.b           = instr.data.rs2_value;
        d_next.csr         = instr.data.csr_read_value;

        unique case (opc)
            OPC_LUI:
            begin
                wr = 1'b1;
                d_next.res_sel = RES_IMM;
                d_next.imm = imm_u;
            end
            OPC_AUIPC:
            begin
                wr = 1'b1;
                d_next.res_sel = RES_PC_IMM;
                d_next.imm = imm_u;
            end
            OPC_JAL:
            begin
                wr = 1'b1;
                d_next.res_sel = RES_PC4;
                d_next.flow = FLOW_JAL;
                d_next.imm = imm_j;
            end
            OPC_JALR:
            begin
                if (f3 != 3'd0)
                    ill = 1'b1;
                wr = 1'b1;
                d_next.res_sel = RES_PC4;
                d_next.flow = FLOW_JALR;
            end
            OPC_BRANCH:
            begin
                unique case (f3) inside
                    BR_EQ, BR_NE, BR_LT, BR_GE, BR_LTU, BR_GEU:
                    begin
                        d_next.flow = FLOW_BRANCH;
                        d_next.imm = imm_b;
                    end
                    default: ill = 1'b1;
                endcase
            end
            OPC_LOAD:
            begin
                if (f3 == LOAD_F3_INVALID)
                    ill = 1'b1;
                wr = 1'b1;
                d_next.mem_kind = MEM_LOAD;
                d_next.mem_size = f3[1:0];
                d_next.load_signed = (f3 < LOAD_F3_UNSIGNED);
            end
            OPC_STORE:
            begin
                if (f3 > STORE_F3_MAX)
                    ill = 1'b1;
                d_next.mem_kind = MEM_STORE;
                d_next.mem_size = f3[1:0];
                d_next.imm = imm_s;
            end
            OPC_OPIMM:
            begin
                wr = 1'b1;
                d_next.res_sel = RES_ALU;
                unique case (f3)
                    F3_ADD:  d_next.alu_op = ALU_ADD;
                    F3_SLT:  d_next.alu_op = ALU_SLT;
                    F3_SLTU: d_next.alu_op = ALU_SLTU;
                    F3_XOR:  d_next.alu_op = ALU_XOR;
                    F3_OR:   d_next.alu_op = ALU_OR;
                    F3_AND:  d_next.alu_op = ALU_AND;
                    F3_SLL:
                    begin
                        d_next.alu_op = ALU_SLL;
                        if (ins[31:26] != F6_BASE)
                            ill = 1'b1;
                    end
                    default:
                    begin
                        if (ins[31:26] == F6_BASE)
                            d_next.alu_op = ALU_SRL;
                        else if (ins[31:26] == F6_ALT)
                            d_next.alu_op = ALU_SRA;
                        else
                            ill = 1'b1;
                    end
                endcase
            end
            OPC_OPIMM32:
            begin
                wr = 1'b1;
                d_next.res_sel = RES_ALU;
                d_next.word = 1'b1;
                if (f3 == F3_ADD)
                    d_next.alu_op = ALU_ADD;
                else if (f3 == F3_SLL && f7 == F7_BASE)
                    d_next.alu_op = ALU_SLL;
                else if (f3 == F3_SR && f7 == F7_BASE)
                    d_next.alu_op = ALU_SRL;
                else if (f3 == F3_SR && f7 == F7_ALT)
                    d_next.alu_op = ALU_SRA;
                else
                    ill = 1'b1;
            end
            OPC_OP:
            begin
                wr = 1'b1;
                d_next.use_imm = 1'b0;
                d_next.res_sel = RES_ALU;
                if (f7 == F7_BASE)
                begin
                    unique case (f3)
                        F3_ADD:  d_next.alu_op = ALU_ADD;
                        F3_SLL:  d_next.alu_op = ALU_SLL;
                        F3_SLT:  d_next.alu_op = ALU_SLT;
                        F3_SLTU: d_next.alu_op = ALU_SLTU;
                        F3_XOR:  d_next.alu_op = ALU_XOR;
                        F3_SR:   d_next.alu_op = ALU_SRL;
                        F3_OR:   d_next.alu_op = ALU_OR;
                        default: d_next.alu_op = ALU_AND;
                    endcase
                end
                else if (f7 == F7_ALT && f3 == F3_ADD)
                    d_next.alu_op = ALU_SUB;
                else if (f7 == F7_ALT && f3 == F3_SR)
                    d_next.alu_op = ALU_SRA;
                else if (f7 == F7_MULDIV)
                    d_next.res_sel = RES_MD;
                else
                    ill = 1'b1;
            end
            OPC_OP32:
            begin
                wr = 1'b1;
                d_next.use_imm = 1'b0;
                d_next.word = 1'b1;
                d_next.res_sel = RES_ALU;
                if (f7 == F7_BASE && f3 == F3_ADD)
                    d_next.alu_op = ALU_ADD;
                else if (f7 == F7_BASE && f3 == F3_SLL)
                    d_next.alu_op = ALU_SLL;
                else if (f7 == F7_BASE && f3 == F3_SR)
                    d_next.alu_op = ALU_SRL;
                else if (f7 == F7_ALT && f3 == F3_ADD)
                    d_next.alu_op = ALU_SUB;
                else if (f7 == F7_ALT && f3 == F3_SR)
                    d_next.alu_op = ALU_SRA;
                else if (f7 == F7_MULDIV && (f3 == F3_ADD || f3[2]))
                    d_next.res_sel = RES_MD;
                else
                    ill = 1'b1;
            end
            OPC_SYSTEM:
            begin
                if (f3 != SYS_F3_PRIV && f3[2] == 1'b0)
                begin
                    wr = 1'b1;
                    d_next.res_sel = RES_CSR;
                    d_next.csr_write = 1'b1;
                end
                else if (ins == INSN_ECALL)
                    d_next.event_res = EV_ECALL;
                else if (ins == INSN_MRET)
                    d_next.event_res = EV_MRET;
                else if (ins == INSN_EBREAK)
                    d_next.event_res = EV_EBREAK;
                else
                    ill = 1'b1;
            end
            default: ill = 1'b1;
        endcase

        // illegal encodings leave only the event and the sequential pc
        if (ill)
        begin
            wr                 = 1'b0;
            d_next.res_sel     = RES_ZERO;
            d_next.flow        = FLOW_SEQ;
            d_next.mem_kind    = MEM_NONE;
            d_next.mem_size    = 2'd0;
            d_next.load_signed = 1'b0;
            d_next.csr_write   = 1'b0;
            d_next.event_res   = EV_ILLEGAL;
        end
        if (ins[11:7] == 5'd0)
            wr = 1'b0;
        if (!wr)
            d_next.res_sel = RES_ZERO;
        d_next.rd_write = wr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (adv)
            v_reg <= instr.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && instr.valid)
            d_reg <= d_next;
    end

endmodule

FILE: rtl/core/rvde_exec.sv
// execute stage: alu, branch and jump targets, memory and csr requests,
// operand preparation for multiply/divide; depends on rvde_pkg
`timescale 1ns / 1ps

module rvde_exec
    import rvde_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  dec_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output ex_t  out_data
);

    logic v_reg;
    ex_t  x_reg;
    ex_t  x_next;
    logic adv;

    assign adv       = !v_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = v_reg;
    assign out_data  = x_reg;

    always_comb
    begin
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] bop;
        logic [63:0] sh_src;
        logic [5:0]  shamt;
        logic [63:0] sum;
        logic [63:0] diff;
        logic [63:0] alu;
        logic [63:0] pc4;
        logic [63:0] target;
        logic        take;
        logic        sgn_a;
        logic        sgn_b;
        logic        is_div;
        logic [63:0] wa;
        logic [63:0] wb;
        logic        na;
        logic        nb;

        a    = in_data.a;
        b    = in_data.b;
        bop  = in_data.use_imm ? in_data.imm : b;
        sum  = a + bop;
        diff = a - bop;
        pc4  = in_data.pc + 64'd4;
        target = in_data.pc + in_data.imm;

        // word shifts take a 32-bit source and a 5-bit amount
        sh_src = a;
        if (in_data.word && in_data.alu_op == ALU_SRL)
            sh_src = {32'b0, a[31:0]};
        else if (in_data.word && in_data.alu_op == ALU_SRA)
            sh_src = sx32(a[31:0]);
        shamt = in_data.word ? {1'b0, bop[4:0]} : bop[5:0];

        case (in_data.alu_op)
            ALU_ADD:  alu = sum;
            ALU_SUB:  alu = diff;
            ALU_SLL:  alu = sh_src << shamt;
            ALU_SLT:  alu = {63'b0, $signed(a) < $signed(bop)};
            ALU_SLTU: alu = {63'b0, a < bop};
            ALU_XOR:  alu = a ^ bop;
            ALU_SRL:  alu = sh_src >> shamt;
            ALU_SRA:  alu = $unsigned($signed(sh_src) >>> shamt);
            ALU_OR:   alu = a | bop;
            default:  alu = a & bop;
        endcase
        if (in_data.word)
            alu = sx32(alu[31:0]);

        case (in_data.br_f3)
            BR_EQ:   take = (a == b);
            BR_NE:   take = (a != b);
            BR_LT:   take = $signed(a) < $signed(b);
            BR_GE:   take = !($signed(a) < $signed(b));
            BR_LTU:  take = a < b;
            BR_GEU:  take = !(a < b);
            default: take = 1'b0;
        endcase

        x_next = '0;
        x_next.c.res.rd_write      = in_data.rd_write;
        x_next.c.res.rd_index      = in_data.rd_index;
        x_next.c.res.mem_kind      = in_data.mem_kind;
        x_next.c.res.mem_size_log2 = in_data.mem_size;
        x_next.c.res.load_signed   = in_data.load_signed;
        x_next.c.res.csr_write     = in_data.csr_write;
        x_next.c.res.event_res     = in_data.event_res;

        case (in_data.flow)
            FLOW_BRANCH: x_next.c.res.next_pc = take ? target : pc4;
            FLOW_JAL:    x_next.c.res.next_pc = target;
            FLOW_JALR:   x_next.c.res.next_pc = {sum[63:1], 1'b0};
            default:     x_next.c.res.next_pc = pc4;
        endcase

        if (in_data.mem_kind != MEM_NONE)
            x_next.c.res.mem_address = sum;
        if (in_data.mem_kind == MEM_STORE)
            x_next.c.res.store_data = b;

        if (in_data.csr_write)
        begin
            case (in_data.csr_op)
                CSR_RW:  x_next.c.res.csr_new_value = a;
                CSR_RS:  x_next.c.res.csr_new_value = in_data.csr | a;
                default: x_next.c.res.csr_new_value = in_data.csr & ~a;
            endcase
        end

        case (in_data.res_sel)
            RES_ALU:    x_next.c.res.rd_value = alu;
            RES_IMM:    x_next.c.res.rd_value = in_data.imm;
            RES_PC_IMM: x_next.c.res.rd_value = target;
            RES_PC4:    x_next.c.res.rd_value = pc4;
            RES_CSR:    x_next.c.res.rd_value = in_data.csr;
            default:    x_next.c.res.rd_value = '0;
        endcase

        // multiply/divide operands: magnitudes for divide, raw for multiply
        sgn_a  = (in_data.md_op == MD_MULH) || (in_data.md_op == MD_MULHSU) ||
                 (in_data.md_op == MD_DIV) || (in_data.md_op == MD_REM);
        sgn_b  = (in_data.md_op == MD_MULH) || (in_data.md_op == MD_DIV) ||
                 (in_data.md_op == MD_REM);
        is_div = in_data.md_op[2];
        wa = a;
        wb = b;
        if (in_data.word)
        begin
            wa = sgn_a ? sx32(a[31:0]) : {32'b0, a[31:0]};
            wb = sgn_b ? sx32(b[31:0]) : {32'b0, b[31:0]};
        end
        na = sgn_a && wa[63];
        nb = sgn_b && wb[63];

        x_next.c.is_md   = (in_data.res_sel == RES_MD);
        x_next.c.md_op   = in_data.md_op;
        x_next.c.md_word = in_data.word;
        x_next.c.neg     = (in_data.md_op == MD_REM) ? na : (na ^ nb);
        x_next.c.bz      = (wb == 64'd0);
        x_next.c.corr    = ((!is_div && sgn_a && a[63]) ? b : 64'd0) +
                           ((!is_div && sgn_b && b[63]) ? a : 64'd0);
        x_next.op_a      = is_div ? (na ? (64'd0 - wa) : wa) : a;
        x_next.op_b      = is_div ? (nb ? (64'd0 - wb) : wb) : b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (adv)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
            x_reg <= x_next;
    end

endmodule

FILE: rtl/core/rvde_muldiv.sv
// multiply/divide pipeline: partial products, product sum, one quotient bit per
// stage, then sign fix and the result register; depends on rvde_pkg, rvde_result_if
`timescale 1ns / 1ps

module rvde_muldiv
    import rvde_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ex_t            in_data,
    rvde_result_if.source  result
);

    localparam int LAST = MD_STAGES - 1;

    logic      v_reg [MD_STAGES];
    carry_t    c_reg [MD_STAGES];
    md_state_t s_reg [MD_STAGES];
    logic      adv   [MD_STAGES];
    logic      out_v_reg;
    result_t   out_reg;
    result_t   out_next;
    logic      out_adv;

    function automatic md_state_t div_step(input md_state_t s);
        md_state_t   o;
        logic [64:0] tmp;
        logic [64:0] diff;
        logic        ge;
        tmp  = {s.r, s.q[63]};
        diff = tmp - {1'b0, s.d};
        ge   = !diff[64];
        o    = s;
        o.r  = ge ? diff[63:0] : tmp[63:0];
        o.q  = {s.q[62:0], ge};
        return o;
    endfunction

    assign out_adv       = !out_v_reg || result.ready;
    assign in_ready      = adv[0];
    assign result.valid  = out_v_reg;
    assign result.data   = out_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MD_STAGES; gi++)
        begin : g_adv
            if (gi == LAST)
            begin : g_last
                assign adv[gi] = !v_reg[gi] || out_adv;
            end
            else
            begin : g_mid
                assign adv[gi] = !v_reg[gi] || adv[gi + 1];
            end
        end
    endgenerate

    // first stage: four 32x32 partial products, or dividend and divisor
    md_state_t s0_next;
    always_comb
    begin
        s0_next = '0;
        if (in_data.c.md_op[2])
        begin
            s0_next.q = in_data.op_a;
            s0_next.d = in_data.op_b;
        end
        else
        begin
            s0_next.q = in_data.op_a[31:0] * in_data.op_b[31:0];
            s0_next.d = in_data.op_a[31:0] * in_data.op_b[63:32];
            s0_next.e = in_data.op_a[63:32] * in_data.op_b[31:0];
            s0_next.r = in_data.op_a[63:32] * in_data.op_b[63:32];
        end
    end

    // second stage: sum of the partial products into high and low words
    md_state_t s1_next;
    always_comb
    begin
        logic [127:0] prod;
        prod = {s_reg[0].r, s_reg[0].q} + {32'b0, s_reg[0].d, 32'b0} +
               {32'b0, s_reg[0].e, 32'b0};
        s1_next = s_reg[0];
        if (!c_reg[0].md_op[2])
        begin
            s1_next.r = prod[127:64];
            s1_next.q = prod[63:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
            v_reg[1] <= 1'b0;
        end
        else
        begin
            if (adv[0])
                v_reg[0] <= in_valid;
            if (adv[1])
                v_reg[1] <= v_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0] && in_valid)
        begin
            c_reg[0] <= in_data.c;
            s_reg[0] <= s0_next;
        end
        if (adv[1] && v_reg[0])
        begin
            c_reg[1] <= c_reg[0];
            s_reg[1] <= s1_next;
        end
    end

    // restoring division, one quotient bit per stage; multiplies pass through
    generate
        for (gi = 2; gi < MD_STAGES; gi++)
        begin : g_div
            md_state_t step_next;
            assign step_next = (c_reg[gi - 1].is_md && c_reg[gi - 1].md_op[2]) ?
                               div_step(s_reg[gi - 1]) : s_reg[gi - 1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[gi] <= 1'b0;
                else if (adv[gi])
                    v_reg[gi] <= v_reg[gi - 1];
            end

            always_ff @(posedge clk)
            begin
                if (adv[gi] && v_reg[gi - 1])
                begin
                    c_reg[gi] <= c_reg[gi - 1];
                    s_reg[gi] <= step_next;
                end
            end
        end
    endgenerate

    // final stage: high-product correction, sign fix, word extension
    always_comb
    begin
        logic [63:0] mh;
        logic [63:0] negv;
        logic [63:0] v;
        carry_t      c;
        md_state_t   s;

        c    = c_reg[LAST];
        s    = s_reg[LAST];
        mh   = s.r - c.corr;
        negv = 64'd0 - ((c.md_op == MD_REM) ? s.r : s.q);
        case (c.md_op)
            MD_MUL:              v = s.q;
            MD_MULH, MD_MULHSU:  v = mh;
            MD_MULHU:            v = s.r;
            MD_DIV:              v = c.bz ? '1 : (c.neg ? negv : s.q);
            MD_DIVU:             v = s.q;
            MD_REM:              v = c.neg ? negv : s.r;
            default:             v = s.r;
        endcase
        if (c.md_word)
            v = sx32(v[31:0]);

        out_next = c.res;
        if (c.is_md)
            out_next.rd_value = v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (out_adv)
            out_v_reg <= v_reg[LAST];
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && v_reg[LAST])
            out_reg <= out_next;
    end

endmodule

FILE: rtl/core/rv64im_decode_execute.sv
// top level of the rv64im decode/execute block: decode, execute, multiply/divide
// depends on rvde_pkg, the channel interfaces, rvde_decode, rvde_exec, rvde_muldiv
`timescale 1ns / 1ps
//
// Usage:
//   instr  - one transaction per instruction: word, pc, rs1/rs2 values and the
//            value of the csr named by bits 31..20, all sampled at acceptance
//   result - one transaction per instruction, in issue order: rd write, next
//            pc, memory request, csr write and the event code
//   Every instruction passes through decode, execute, two multiply stages,
//   64 divide stages (one quotient bit each) and the result register. All
//   instructions take the same path, so results never reorder.
//   Throughput is one instruction per cycle while the pipe is not full; every
//   stage is a register with its own valid bit, so a new transaction is taken
//   each cycle unless back-pressure from result.ready has filled the pipe.
//   When result.ready is low the result register holds; earlier stages keep
//   filling empty slots and instr.ready falls only once the whole pipe is
//   full. Nothing is dropped or replayed.
//   Reset clears all valid bits; the pipe is empty and ready in the first
//   cycle after reset is released.
//   Ecall, mret, ebreak and illegal encodings are only flagged in event_res.
//
`include "rv64im_decode_execute_macros.svh"

module rv64im_decode_execute
    import rvde_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    rvde_instr_if.sink     instr,
    rvde_result_if.source  result
);

    logic dec_valid;
    logic dec_ready;
    dec_t dec_data;
    logic ex_valid;
    logic ex_ready;
    ex_t  ex_data;

    rvde_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .instr     (instr),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_data  (dec_data)
    );

    rvde_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (ex_valid),
        .out_ready (ex_ready),
        .out_data  (ex_data)
    );

    rvde_muldiv u_muldiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (ex_valid),
        .in_ready (ex_ready),
        .in_data  (ex_data),
        .result   (result)
    );

    `RVDE_ASSERT_NOW(a_event_quiet, result.valid && result.data.event_res != EV_NONE, !result.data.rd_write && result.data.mem_kind == MEM_NONE && !result.data.csr_write, "event result carries side effects")
    `RVDE_ASSERT_NOW(a_x0_no_write, result.valid && result.data.rd_index == 5'd0, !result.data.rd_write, "write to x0")
    `RVDE_ASSERT_NOW(a_load_value, result.valid && result.data.mem_kind == MEM_LOAD, result.data.rd_value == 64'd0, "load with nonzero rd value")

endmodule

FILE: verif/tb_rv64im_decode_execute.sv
// self-checking testbench for the rv64im decode/execute block
// predicts each result from the instruction operands and compares in order
// depends on rvde_pkg, rvde_instr_if, rvde_result_if and the block itself
`timescale 1ns / 1ps

module tb_rv64im_decode_execute;
    import rvde_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;

    logic clk;
    logic rst_n;

    rvde_instr_if  instr_ch ();
    rvde_result_if result_ch ();

    rv64im_decode_execute i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_ch.sink),
        .result (result_ch.source)
    );

    result_t expected_results[$];
    int      mismatch_count;
    int      unexpected_count;
    int      sent_count;
    int      checked_count;
    int      idle_pct;
    int      stall_pct;
    int      idle_cycles;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // ---------------------------------------------------------------- predictor
    function automatic logic [63:0] sext(input logic [63:0] v, input int n);
        logic [63:0] m;
        m = 64'd1 << (n - 1);
        v = v & ((m << 1) - 64'd1);
        return (v ^ m) - m;
    endfunction

    function automatic logic signed_lt(input logic [63:0] x, input logic [63:0] y);
        return $signed(x) < $signed(y);
    endfunction

    function automatic logic [63:0] mul_high(input logic [63:0] x, input logic [63:0] y,
                                             input logic x_signed, input logic y_signed);
        logic [127:0] ex;
        logic [127:0] ey;
        logic [127:0] prod;
        ex = x_signed ? {{64{x[63]}}, x} : {64'd0, x};
        ey = y_signed ? {{64{y[63]}}, y} : {64'd0, y};
        prod = ex * ey;
        return prod[127:64];
    endfunction

    function automatic logic [63:0] div_signed(input logic [63:0] x, input logic [63:0] y,
                                               input logic want_rem);
        logic [63:0] ux;
        logic [63:0] uy;
        logic [63:0] r;
        ux = x[63] ? -x : x;
        uy = y[63] ? -y : y;
        if (y == 64'd0)
            return want_rem ? x : '1;
        if (want_rem)
        begin
            r = ux % uy;
            return x[63] ? -r : r;
        end
        r = ux / uy;
        return (x[63] != y[63]) ? -r : r;
    endfunction

    function automatic result_t execute_instruction(input instr_t it);
        result_t     o;
        logic [31:0] w;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [63:0] a, b, csr, pc;
        logic [63:0] imm_i, imm_s, imm_b, imm_j, imm_u;
        logic [63:0] a32, b32, val;
        logic [5:0]  sh6;
        logic [4:0]  sh5;
        logic        wr, ill, take;
        w = it.instruction; pc = it.pc; a = it.rs1_value; b = it.rs2_value;
        csr = it.csr_read_value;
        opc = w[6:0]; f3 = w[14:12]; f7 = w[31:25];
        imm_i = sext({52'd0, w[31:20]}, 12);
        imm_s = sext({52'd0, w[31:25], w[11:7]}, 12);
        imm_b = sext({51'd0, w[31], w[7], w[30:25], w[11:8], 1'b0}, 13);
        imm_j = sext({43'd0, w[31], w[19:12], w[20], w[30:21], 1'b0}, 21);
        imm_u = sext({32'd0, w[31:12], 12'd0}, 32);
        sh6 = w[25:20]; sh5 = w[24:20];
        a32 = {32'd0, a[31:0]}; b32 = {32'd0, b[31:0]};
        o = '0;
        o.rd_index = w[11:7];
        o.next_pc = pc + 64'd4;
        wr = 1'b0; ill = 1'b0; take = 1'b0; val = '0;
        case (opc)
            OPC_LUI: begin wr = 1; val = imm_u; end
            OPC_AUIPC: begin wr = 1; val = pc + imm_u; end
            OPC_JAL: begin wr = 1; val = pc + 64'd4; o.next_pc = pc + imm_j; end
            OPC_JALR:
            begin
                if (f3 != 3'd0) ill = 1;
                else
                begin
                    wr = 1; val = pc + 64'd4; o.next_pc = (a + imm_i) & ~64'd1;
                end
            end
            OPC_BRANCH:
            begin
                case (f3)
                    BR_EQ:  take = a == b;
                    BR_NE:  take = a != b;
                    BR_LT:  take = signed_lt(a, b);
                    BR_GE:  take = !signed_lt(a, b);
                    BR_LTU: take = a < b;
                    BR_GEU: take = a >= b;
                    default: ill = 1;
                endcase
                if (take) o.next_pc = pc + imm_b;
            end
            OPC_LOAD:
            begin
                if (f3 == LOAD_F3_INVALID) ill = 1;
                else
                begin
                    wr = 1; o.mem_kind = MEM_LOAD; o.mem_address = a + imm_i;
                    o.mem_size_log2 = f3[1:0]; o.load_signed = f3 < LOAD_F3_UNSIGNED;
                end
            end
            OPC_STORE:
            begin
                if (f3 > STORE_F3_MAX) ill = 1;
                else
                begin
                    o.mem_kind = MEM_STORE; o.mem_address = a + imm_s;
                    o.mem_size_log2 = f3[1:0]; o.store_data = b;
                end
            end
            OPC_OPIMM:
            begin
                wr = 1;
                case (f3)
                    F3_ADD:  val = a + imm_i;
                    F3_SLT:  val = {63'd0, signed_lt(a, imm_i)};
                    F3_SLTU: val = {63'd0, a < imm_i};
                    F3_XOR:  val = a ^ imm_i;
                    F3_OR:   val = a | imm_i;
                    F3_AND:  val = a & imm_i;
                    F3_SLL:  if (w[31:26] == F6_BASE) val = a << sh6; else ill = 1;
                    default:
                        if (w[31:26] == F6_BASE) val = a >> sh6;
                        else if (w[31:26] == F6_ALT) val = $signed(a) >>> sh6;
                        else ill = 1;
                endcase
            end
            OPC_OPIMM32:
            begin
                wr = 1;
                if (f3 == F3_ADD) val = sext(a + imm_i, 32);
                else if (f3 == F3_SLL && f7 == F7_BASE) val = sext(a32 << sh5, 32);
                else if (f3 == F3_SR && f7 == F7_BASE) val = sext(a32 >> sh5, 32);
                else if (f3 == F3_SR && f7 == F7_ALT) val = $signed(sext(a32, 32)) >>> sh5;
                else ill = 1;
            end
            OPC_OP:
            begin
                wr = 1;
                if (f7 == F7_BASE)
                begin
                    case (f3)
                        F3_ADD:  val = a + b;
                        F3_SLL:  val = a << b[5:0];
                        F3_SLT:  val = {63'd0, signed_lt(a, b)};
                        F3_SLTU: val = {63'd0, a < b};
                        F3_XOR:  val = a ^ b;
                        F3_SR:   val = a >> b[5:0];
                        F3_OR:   val = a | b;
                        default: val = a & b;
                    endcase
                end
                else if (f7 == F7_ALT)
                begin
                    if (f3 == F3_ADD) val = a - b;
                    else if (f3 == F3_SR) val = $signed(a) >>> b[5:0];
                    else ill = 1;
                end
                else if (f7 == F7_MULDIV)
                begin
                    case (md_op_t'(f3))
                        MD_MUL:    val = a * b;
                        MD_MULH:   val = mul_high(a, b, 1, 1);
                        MD_MULHSU: val = mul_high(a, b, 1, 0);
                        MD_MULHU:  val = mul_high(a, b, 0, 0);
                        MD_DIV:    val = div_signed(a, b, 0);
                        MD_DIVU:   val = (b == 0) ? '1 : a / b;
                        MD_REM:    val = div_signed(a, b, 1);
                        default:   val = (b == 0) ? a : a % b;
                    endcase
                end
                else ill = 1;
            end
            OPC_OP32:
            begin
                wr = 1;
                if (f7 == F7_BASE && f3 == F3_ADD) val = sext(a + b, 32);
                else if (f7 == F7_BASE && f3 == F3_SLL) val = sext(a32 << b[4:0], 32);
                else if (f7 == F7_BASE && f3 == F3_SR) val = sext(a32 >> b[4:0], 32);
                else if (f7 == F7_ALT && f3 == F3_ADD) val = sext(a - b, 32);
                else if (f7 == F7_ALT && f3 == F3_SR)
                    val = $signed(sext(a32, 32)) >>> b[4:0];
                else if (f7 == F7_MULDIV && f3 == MD_MUL) val = sext(a32 * b32, 32);
                else if (f7 == F7_MULDIV && f3 == MD_DIV)
                    val = sext(div_signed(sext(a32, 32), sext(b32, 32), 0), 32);
                else if (f7 == F7_MULDIV && f3 == MD_DIVU)
                    val = (b32 == 0) ? '1 : sext(a32 / b32, 32);
                else if (f7 == F7_MULDIV && f3 == MD_REM)
                    val = sext(div_signed(sext(a32, 32), sext(b32, 32), 1), 32);
                else if (f7 == F7_MULDIV && f3 == MD_REMU)
                    val = sext((b32 == 0) ? a32 : a32 % b32, 32);
                else ill = 1;
            end
            OPC_SYSTEM:
            begin
                if (f3 >= 3'd1 && f3 <= 3'd3)
                begin
                    wr = 1; val = csr; o.csr_write = 1;
                    case (f3[1:0])
                        CSR_RW:  o.csr_new_value = a;
                        CSR_RS:  o.csr_new_value = csr | a;
                        default: o.csr_new_value = csr & ~a;
                    endcase
                end
                else if (w == INSN_ECALL) o.event_res = EV_ECALL;
                else if (w == INSN_MRET) o.event_res = EV_MRET;
                else if (w == INSN_EBREAK) o.event_res = EV_EBREAK;
                else ill = 1;
            end
            default: ill = 1;
        endcase
        if (ill)
        begin
            o = '0;
            o.rd_index = w[11:7];
            o.next_pc = pc + 64'd4;
            o.event_res = EV_ILLEGAL;
            wr = 0;
        end
        if (o.mem_kind == MEM_LOAD || !wr || o.rd_index == 5'd0) val = '0;
        if (o.rd_index == 5'd0) wr = 0;
        o.rd_write = wr;
        o.rd_value = val;
        return o;
    endfunction

    // ---------------------------------------------------------------- driving
    // valid stays high after acceptance; the next call or the caller drops it
    task automatic send_instruction(input logic [31:0] w, input logic [63:0] pc,
                                    input logic [63:0] a, input logic [63:0] b,
                                    input logic [63:0] csr);
        instr_t it;
        it.instruction = w; it.pc = pc; it.rs1_value = a; it.rs2_value = b;
        it.csr_read_value = csr;
        while ($urandom_range(99) < idle_pct)
        begin
            instr_ch.valid <= 1'b0;
            @(posedge clk);
        end
        instr_ch.valid <= 1'b1;
        instr_ch.data  <= it;
        @(posedge clk);
        while (!instr_ch.ready) @(posedge clk);
        expected_results.push_back(execute_instruction(it));
        sent_count++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] interesting64();
        case ($urandom_range(9))
            0: return 64'd0;
            1: return 64'hffff_ffff_ffff_ffff;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h7fff_ffff_ffff_ffff;
            4: return 64'h0000_0000_8000_0000;
            5: return 64'h0000_0000_ffff_ffff;
            6: return 64'd1;
            7: return 64'($urandom_range(70));
            default: return rand64();
        endcase
    endfunction

    // well-formed instruction of a random class with random fields
    function automatic logic [31:0] legal_word();
        logic [31:0] w;
        logic [2:0]  f3;
        w = $urandom();
        f3 = w[14:12];
        case ($urandom_range(13))
            0: w[6:0] = OPC_LUI;
            1: w[6:0] = OPC_AUIPC;
            2: w[6:0] = OPC_JAL;
            3: begin w[6:0] = OPC_JALR; w[14:12] = 3'd0; end
            4: begin w[6:0] = OPC_BRANCH; if (f3 == 2 || f3 == 3) w[14] = 1'b1; end
            5: begin w[6:0] = OPC_LOAD; if (f3 == 7) w[12] = 1'b0; end
            6: begin w[6:0] = OPC_STORE; w[14] = 1'b0; end
            7:
            begin
                w[6:0] = OPC_OPIMM;
                if (f3 == F3_SLL) w[31:26] = F6_BASE;
                if (f3 == F3_SR) w[31:26] = $urandom_range(1) ? F6_ALT : F6_BASE;
            end
            8:
            begin
                w[6:0] = OPC_OPIMM32;
                case ($urandom_range(3))
                    0: w[14:12] = F3_ADD;
                    1: begin w[14:12] = F3_SLL; w[31:25] = F7_BASE; end
                    2: begin w[14:12] = F3_SR;  w[31:25] = F7_BASE; end
                    default: begin w[14:12] = F3_SR; w[31:25] = F7_ALT; end
                endcase
            end
            9, 10:
            begin
                w[6:0] = OPC_OP;
                case ($urandom_range(2))
                    0: w[31:25] = F7_BASE;
                    1: begin w[31:25] = F7_ALT; w[14:12] = $urandom_range(1) ? F3_SR : F3_ADD; end
                    default: w[31:25] = F7_MULDIV;
                endcase
            end
            11:
            begin
                w[6:0] = OPC_OP32;
                case ($urandom_range(2))
                    0: begin w[31:25] = F7_BASE; w[14:12] = $urandom_range(1) ? F3_SR : F3_ADD;
                             if ($urandom_range(2) == 0) w[14:12] = F3_SLL; end
                    1: begin w[31:25] = F7_ALT; w[14:12] = $urandom_range(1) ? F3_SR : F3_ADD; end
                    default: begin w[31:25] = F7_MULDIV; if (f3 inside {1, 2, 3}) w[14] = 1'b1; end
                endcase
            end
            12: begin w[6:0] = OPC_SYSTEM; w[14:12] = 3'($urandom_range(1, 3)); end
            default:
                case ($urandom_range(2))
                    0: w = INSN_ECALL;
                    1: w = INSN_MRET;
                    default: w = INSN_EBREAK;
                endcase
        endcase
        return w;
    endfunction

    // ---------------------------------------------------------------- checking
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        result_t exp_r;
        result_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = result_ch.data;
            if (expected_results.size() == 0)
            begin
                unexpected_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("mismatch: result transaction with nothing expected: %h", got);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                checked_count++;
                if (got !== exp_r)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch #%0d: wr %b/%b rd %0d/%0d val %h/%h npc %h/%h ",
                                  "mem %0d/%0d addr %h/%h sz %0d/%0d sg %b/%b sd %h/%h ",
                                  "cw %b/%b cnew %h/%h ev %0d/%0d (expected/actual)"},
                                 checked_count, exp_r.rd_write, got.rd_write,
                                 exp_r.rd_index, got.rd_index, exp_r.rd_value, got.rd_value,
                                 exp_r.next_pc, got.next_pc, exp_r.mem_kind, got.mem_kind,
                                 exp_r.mem_address, got.mem_address,
                                 exp_r.mem_size_log2, got.mem_size_log2,
                                 exp_r.load_signed, got.load_signed,
                                 exp_r.store_data, got.store_data,
                                 exp_r.csr_write, got.csr_write,
                                 exp_r.csr_new_value, got.csr_new_value,
                                 exp_r.event_res, got.event_res);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("** rv64im_decode_execute: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests
    task automatic test_upper_and_jumps();
        send_instruction({20'hfffff, 5'd1, OPC_LUI}, rand64(), 0, 0, 0);
        send_instruction({20'h80000, 5'd2, OPC_AUIPC}, 64'hffff_ffff_ffff_fff0, 0, 0, 0);
        send_instruction({1'b1, 10'h3ff, 1'b1, 8'hff, 5'd3, OPC_JAL}, 64'h1000, 0, 0, 0);
        send_instruction({12'h7ff, 5'd1, 3'd0, 5'd31, OPC_JALR}, 64'h40, 64'h101, 0, 0);
        send_instruction({12'h800, 5'd1, 3'd0, 5'd0, OPC_JALR}, 64'h40, 64'h0, 0, 0);
    endtask

    task automatic test_branches();
        send_instruction({1'b1, 6'h3f, 5'd2, 5'd1, BR_EQ, 4'hf, 1'b1, OPC_BRANCH},
                         64'h2000, 64'd5, 64'd5, 0);
        send_instruction({1'b0, 6'h01, 5'd2, 5'd1, BR_NE, 4'h2, 1'b0, OPC_BRANCH},
                         64'h2000, 64'd5, 64'd5, 0);
        send_instruction({1'b0, 6'h01, 5'd2, 5'd1, BR_LT, 4'h2, 1'b0, OPC_BRANCH},
                         64'h2000, 64'h8000_0000_0000_0000, 64'd1, 0);
        send_instruction({1'b0, 6'h01, 5'd2, 5'd1, BR_GEU, 4'h2, 1'b0, OPC_BRANCH},
                         64'h2000, 64'h8000_0000_0000_0000, 64'd1, 0);
    endtask

    task automatic test_memory();
        send_instruction({12'h800, 5'd1, 3'd0, 5'd4, OPC_LOAD}, 0, 64'd0, 0, 0);
        send_instruction({12'h7ff, 5'd1, LOAD_F3_UNSIGNED, 5'd4, OPC_LOAD}, 0, '1, 0, 0);
        send_instruction({7'h7f, 5'd2, 5'd1, 3'd3, 5'h1f, OPC_STORE}, 0, 64'h10, '1, 0);
    endtask

    task automatic test_muldiv_corners();
        logic [63:0] most_neg;
        most_neg = 64'h8000_0000_0000_0000;
        send_instruction({F7_MULDIV, 5'd2, 5'd1, 3'(MD_DIV), 5'd5, OPC_OP}, 0, most_neg, '1, 0);
        send_instruction({F7_MULDIV, 5'd2, 5'd1, 3'(MD_REM), 5'd5, OPC_OP}, 0, most_neg, '1, 0);
        send_instruction({F7_MULDIV, 5'd2, 5'd1, 3'(MD_DIVU), 5'd5, OPC_OP}, 0, 64'd9, 0, 0);
        send_instruction({F7_MULDIV, 5'd2, 5'd1, 3'(MD_REM), 5'd5, OPC_OP}, 0, 64'd9, 0, 0);
        send_instruction({F7_MULDIV, 5'd2, 5'd1, 3'(MD_DIV), 5'd5, OPC_OP32}, 0,
                         64'h8000_0000, 64'hffff_ffff, 0);
        send_instruction({F7_MULDIV, 5'd2, 5'd1, 3'(MD_REMU), 5'd5, OPC_OP32}, 0,
                         64'h1_8000_0000, 64'h1_0000_0000, 0);
        send_instruction({F7_MULDIV, 5'd2, 5'd1, 3'(MD_MULHSU), 5'd5, OPC_OP}, 0,
                         '1, '1, 0);
    endtask

    task automatic test_system_and_illegal();
        send_instruction({12'h300, 5'd1, 3'(CSR_RC), 5'd6, OPC_SYSTEM}, 0, 64'hf0, 0, '1);
        send_instruction({12'h300, 5'd0, 3'(CSR_RS), 5'd6, OPC_SYSTEM}, 0, 0, 0, 64'h5);
        send_instruction(INSN_ECALL, 64'h10, 0, 0, 0);
        send_instruction(INSN_MRET, 64'h10, 0, 0, 0);
        send_instruction(INSN_EBREAK, 64'h10, 0, 0, 0);
        send_instruction({F6_ALT, 6'd3, 5'd1, F3_SLL, 5'd7, OPC_OPIMM}, 0, 1, 0, 0);
        send_instruction(32'h0000_000f, 0, 0, 0, 0);
        send_instruction(32'hffff_ffff, '1, '1, '1, '1);
    endtask

    task automatic test_random(input int count);
        logic [31:0] w;
        for (int n = 0; n < count; n++)
        begin
            // quiet stretch with no idling on either side
            if (n == count / 3) begin idle_pct = 0; stall_pct = 0; end
            if (n == count / 2) begin idle_pct = 38; stall_pct = 38; end
            w = ($urandom_range(99) < 85) ? legal_word() : $urandom();
            send_instruction(w, rand64(), interesting64(), interesting64(), rand64());
        end
    endtask

    initial
    begin
        int drain;
        mismatch_count = 0; unexpected_count = 0; sent_count = 0; checked_count = 0;
        idle_cycles = 0; idle_pct = 38; stall_pct = 38;
        rst_n = 1'b0;
        instr_ch.valid = 1'b0;
        instr_ch.data  = '0;
        result_ch.ready = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_upper_and_jumps();
        test_branches();
        test_memory();
        test_muldiv_corners();
        test_system_and_illegal();
        test_random(1450);
        instr_ch.valid <= 1'b0;

        drain = 0;
        while (expected_results.size() != 0 && drain < 200000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            mismatch_count++;
            $display("%0d expected results never arrived", expected_results.size());
        end
        $display("run covered %0d instructions (directed corners, then random legal and junk words)",
                 sent_count);
        $display("%0d results checked, %0d mismatches", checked_count, mismatch_count);
        if (mismatch_count == 0)
            $display("** rv64im_decode_execute: PASSED **");
        else
            $display("** rv64im_decode_execute: FAILED **");
        $finish;
    end

endmodule

FILE: rv64im_decode_execute.f
+incdir+rtl/core
rtl/core/rvde_pkg.sv
rtl/core/rvde_instr_if.sv
rtl/core/rvde_result_if.sv
rtl/core/rvde_decode.sv
rtl/core/rvde_exec.sv
rtl/core/rvde_muldiv.sv
rtl/core/rv64im_decode_execute.sv
verif/tb_rv64im_decode_execute.sv
